@@ rtl/sbsm_pkg.sv @@
// ----------------------------------------------------------------------------
// sbsm_pkg
// Types and constants shared by the serial bank switch mapper.
// ----------------------------------------------------------------------------
package sbsm_pkg;

  localparam logic [1:0] ACT_CPU_READ  = 2'd0;
  localparam logic [1:0] ACT_CPU_WRITE = 2'd1;
  localparam logic [1:0] ACT_PPU_READ  = 2'd2;
  localparam logic [1:0] ACT_PPU_WRITE = 2'd3;

  localparam logic [1:0] TGT_CONTROL  = 2'd0;
  localparam logic [1:0] TGT_CHR_LOW  = 2'd1;
  localparam logic [1:0] TGT_CHR_HIGH = 2'd2;
  localparam logic [1:0] TGT_PRG      = 2'd3;

  localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

  localparam logic [0:0] CFG_PRG_BANK_COUNT = 1'd0;
  localparam logic [0:0] CFG_CHR_BANK_COUNT = 1'd1;

  localparam logic [4:0] CONTROL_RESET   = 5'h1C;
  localparam logic [4:0] PRG_COUNT_RESET = 5'd16;
  localparam logic [2:0] SHIFT_BITS      = 3'd5;

  localparam int CFG_WIDTH = 5;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [17:0] mapped_address;
    logic [1:0]  mirroring;
  } rsp_t;

  typedef struct packed {
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [3:0] prg_low;
    logic [3:0] prg_high;
    logic       chr_ram;
    logic [1:0] mirror_next;
  } bank_t;

endpackage

@@ rtl/sbsm_regs.sv @@
// ----------------------------------------------------------------------------
// sbsm_regs
// Serial load register, bank select registers and bank windows.
// ----------------------------------------------------------------------------
module sbsm_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  sbsm_pkg::req_t                 req,
  input  logic                           cfg_write,
  input  logic [0:0]                     cfg_index,
  input  logic [sbsm_pkg::CFG_WIDTH-1:0] cfg_data,
  output sbsm_pkg::bank_t                banks
);
  import sbsm_pkg::*;

  logic [4:0] prg_bank_count;
  logic [4:0] chr_bank_count;
  logic [4:0] shift_value;
  logic [2:0] shift_count;
  logic [4:0] control_word;
  logic [4:0] chr_select_low;
  logic [4:0] chr_select_high;
  logic [3:0] prg_select;
  logic [4:0] chr_low;
  logic [4:0] chr_high;
  logic [3:0] prg_low;
  logic [3:0] prg_high;
  logic [1:0] mirror_mode;

  logic [4:0] shift_value_next;
  logic [2:0] shift_count_next;
  logic [4:0] control_word_next;
  logic [4:0] chr_select_low_next;
  logic [4:0] chr_select_high_next;
  logic [3:0] prg_select_next;
  logic [4:0] chr_low_next;
  logic [4:0] chr_high_next;
  logic [3:0] prg_low_next;
  logic [3:0] prg_high_next;
  logic [1:0] mirror_mode_next;
  logic [3:0] last_bank;
  logic [3:0] cfg_last_bank;
  logic [4:0] loaded;
  logic [2:0] count_inc;
  logic       serial_write;

  assign last_bank     = 4'(prg_bank_count - 5'd1);
  assign cfg_last_bank = 4'(cfg_data - 5'd1);
  assign serial_write  = accept && (req.action == ACT_CPU_WRITE) && req.bus_address[15];
  assign loaded        = {req.write_data[0], shift_value[4:1]};
  assign count_inc     = shift_count + 3'd1;

  always_comb begin
    shift_value_next     = shift_value;
    shift_count_next     = shift_count;
    control_word_next    = control_word;
    chr_select_low_next  = chr_select_low;
    chr_select_high_next = chr_select_high;
    prg_select_next      = prg_select;
    chr_low_next         = chr_low;
    chr_high_next        = chr_high;
    prg_low_next         = prg_low;
    prg_high_next        = prg_high;
    mirror_mode_next     = mirror_mode;
    if (serial_write) begin
      if (req.write_data[7]) begin
        shift_value_next  = '0;
        shift_count_next  = '0;
        control_word_next = control_word | 5'h0C;
      end else if (count_inc != SHIFT_BITS) begin
        shift_value_next = loaded;
        shift_count_next = count_inc;
      end else begin
        shift_value_next = '0;
        shift_count_next = '0;
        unique case (req.bus_address[14:13])
          TGT_CONTROL: begin
            control_word_next = loaded;
            mirror_mode_next  = loaded[1:0];
          end
          TGT_CHR_LOW:  chr_select_low_next  = loaded;
          TGT_CHR_HIGH: chr_select_high_next = loaded;
          TGT_PRG:      prg_select_next      = loaded[3:0];
          default:      prg_select_next      = prg_select;
        endcase
        if (control_word_next[4]) begin
          chr_low_next  = chr_select_low_next;
          chr_high_next = chr_select_high_next;
        end else begin
          chr_low_next  = {chr_select_low_next[4:1], 1'b0};
          chr_high_next = {chr_select_low_next[4:1], 1'b1};
        end
        unique case (control_word_next[3:2])
          PRG_MODE_FIX_LOW: begin
            prg_low_next  = '0;
            prg_high_next = prg_select_next;
          end
          PRG_MODE_FIX_HIGH: begin
            prg_low_next  = prg_select_next;
            prg_high_next = last_bank;
          end
          default: begin
            prg_low_next  = {prg_select_next[3:1], 1'b0};
            prg_high_next = {prg_select_next[3:1], 1'b1};
          end
        endcase
      end
    end
    if (cfg_write && (cfg_index == CFG_PRG_BANK_COUNT)) begin
      prg_high_next = cfg_last_bank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count  <= PRG_COUNT_RESET;
      chr_bank_count  <= '0;
      shift_value     <= '0;
      shift_count     <= '0;
      control_word    <= CONTROL_RESET;
      chr_select_low  <= '0;
      chr_select_high <= '0;
      prg_select      <= '0;
      chr_low         <= 5'd0;
      chr_high        <= 5'd1;
      prg_low         <= '0;
      prg_high        <= 4'(PRG_COUNT_RESET - 5'd1);
      mirror_mode     <= '0;
    end else begin
      shift_value     <= shift_value_next;
      shift_count     <= shift_count_next;
      control_word    <= control_word_next;
      chr_select_low  <= chr_select_low_next;
      chr_select_high <= chr_select_high_next;
      prg_select      <= prg_select_next;
      chr_low         <= chr_low_next;
      chr_high        <= chr_high_next;
      prg_low         <= prg_low_next;
      prg_high        <= prg_high_next;
      mirror_mode     <= mirror_mode_next;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_PRG_BANK_COUNT: prg_bank_count <= cfg_data;
          CFG_CHR_BANK_COUNT: chr_bank_count <= cfg_data;
          default:            chr_bank_count <= chr_bank_count;
        endcase
      end
    end
  end

  assign banks.chr_low     = chr_low;
  assign banks.chr_high    = chr_high;
  assign banks.prg_low     = prg_low;
  assign banks.prg_high    = prg_high;
  assign banks.chr_ram     = (chr_bank_count == 5'd0);
  assign banks.mirror_next = mirror_mode_next;

endmodule

@@ rtl/sbsm_xlate.sv @@
// ----------------------------------------------------------------------------
// sbsm_xlate
// Address translation of one bus access through the current bank windows.
// ----------------------------------------------------------------------------
module sbsm_xlate (
  input  sbsm_pkg::req_t  req,
  input  sbsm_pkg::bank_t banks,
  output sbsm_pkg::rsp_t  rsp
);
  import sbsm_pkg::*;

  logic [4:0] chr_bank;

  assign chr_bank = req.bus_address[12] ? banks.chr_high : banks.chr_low;

  always_comb begin
    rsp.hit            = 1'b0;
    rsp.mapped_address = '0;
    rsp.mirroring      = banks.mirror_next;
    unique case (req.action)
      ACT_CPU_READ: begin
        if (req.bus_address[15]) begin
          rsp.hit            = 1'b1;
          rsp.mapped_address = req.bus_address[14]
                             ? {banks.prg_high, req.bus_address[13:0]}
                             : {banks.prg_low, req.bus_address[13:0]};
        end
      end
      ACT_CPU_WRITE: rsp.hit = 1'b0;
      default: begin
        if (req.bus_address[15:13] == 3'd0) begin
          if (banks.chr_ram) begin
            rsp.hit            = 1'b1;
            rsp.mapped_address = {2'b00, req.bus_address};
          end else if (req.action == ACT_PPU_READ) begin
            rsp.hit            = 1'b1;
            rsp.mapped_address = {1'b0, chr_bank, req.bus_address[11:0]};
          end
        end
      end
    endcase
  end

endmodule

@@ rtl/serial_bank_switch_mapper.sv @@
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper
// Cartridge bank switcher: serial register writes and CPU/PPU address mapping.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   action, bus_address, write_data
//   rsp      out  rsp_valid/rsp_stall   hit, mapped_address, mirroring
//   cfg      in   cfg_write             cfg_index, cfg_data
//
// One request per cycle unless req_stall is high; its response appears in the
// cycle after it is taken, from the single result register. Reset is
// synchronous and clears the mapper to its power-up banks. req_stall rises
// only while a response is held by rsp_stall.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  sbsm_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output sbsm_pkg::rsp_t                 rsp,
  input  logic                           cfg_write,
  input  logic [0:0]                     cfg_index,
  input  logic [sbsm_pkg::CFG_WIDTH-1:0] cfg_data
);
  import sbsm_pkg::*;

  logic  accept;
  bank_t banks;
  rsp_t  rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  sbsm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .banks     (banks)
  );

  sbsm_xlate u_xlate (
    .req   (req),
    .banks (banks),
    .rsp   (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!req_stall) begin
      rsp_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  a_write_no_hit: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == ACT_CPU_WRITE) |=> (rsp_valid && !rsp.hit))
    else $error("cpu write response claims a hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.hit) |-> (rsp.mapped_address == 18'd0))
    else $error("missed access carries a nonzero address");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("request stalled with no response pending");

endmodule

@@ sim/sbsm_bus_checker.sv @@
// ----------------------------------------------------------------------------
// sbsm_bus_checker
// Watches the request, response and register ports of the bank switch mapper.
// Keeps its own copy of the serial load register, the bank selects, the
// mapping windows and the bank counts. For every request it computes the
// expected response and queues it. Each response is compared field by field
// with the oldest entry in the queue.
// ----------------------------------------------------------------------------
module sbsm_bus_checker import sbsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  req_t                  req,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  rsp_t                  rsp,
  input  logic                  cfg_write,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_WIDTH-1:0]  cfg_data,
  output int                    fails,
  output int                    outstanding
);

  logic [4:0] prg_count;
  logic [4:0] chr_count;
  logic [4:0] load_value;
  logic [2:0] load_count;
  logic [4:0] control;
  logic [4:0] chr_sel_low;
  logic [4:0] chr_sel_high;
  logic [3:0] prg_sel;
  logic [4:0] chr_bank_low;
  logic [4:0] chr_bank_high;
  logic [3:0] prg_bank_low;
  logic [3:0] prg_bank_high;
  logic [1:0] mirror;
  rsp_t       expected_rsps[$];
  int         fail_count = 0;

  function automatic logic [3:0] last_prg_bank();
    return 4'(prg_count - 5'd1);
  endfunction

  function automatic void reload_windows();
    if (control[4]) begin
      chr_bank_low  = chr_sel_low;
      chr_bank_high = chr_sel_high;
    end else begin
      chr_bank_low  = {chr_sel_low[4:1], 1'b0};
      chr_bank_high = chr_bank_low + 5'd1;
    end
    case (control[3:2])
      PRG_MODE_FIX_LOW: begin
        prg_bank_low  = 4'd0;
        prg_bank_high = prg_sel;
      end
      PRG_MODE_FIX_HIGH: begin
        prg_bank_low  = prg_sel;
        prg_bank_high = last_prg_bank();
      end
      default: begin
        prg_bank_low  = {prg_sel[3:1], 1'b0};
        prg_bank_high = prg_bank_low + 4'd1;
      end
    endcase
  endfunction

  function automatic void shift_in(input req_t r);
    if (!r.bus_address[15]) return;
    if (r.write_data[7]) begin
      load_value = '0;
      load_count = '0;
      control    = control | 5'h0C;
      return;
    end
    load_value = {r.write_data[0], load_value[4:1]};
    load_count = load_count + 3'd1;
    if (load_count != SHIFT_BITS) return;
    case (r.bus_address[14:13])
      TGT_CONTROL: begin
        control = load_value;
        mirror  = load_value[1:0];
      end
      TGT_CHR_LOW:  chr_sel_low  = load_value;
      TGT_CHR_HIGH: chr_sel_high = load_value;
      default:      prg_sel      = load_value[3:0];
    endcase
    reload_windows();
    load_value = '0;
    load_count = '0;
  endfunction

  function automatic rsp_t map_access(input req_t r);
    rsp_t       o;
    logic [4:0] chr_bank;
    o = '0;
    case (r.action)
      ACT_CPU_READ: begin
        if (r.bus_address[15]) begin
          o.hit            = 1'b1;
          o.mapped_address = {r.bus_address[14] ? prg_bank_high : prg_bank_low,
                              r.bus_address[13:0]};
        end
      end
      ACT_CPU_WRITE: shift_in(r);
      default: begin
        if (r.bus_address < 16'h2000) begin
          if (chr_count == 5'd0) begin
            o.hit            = 1'b1;
            o.mapped_address = 18'(r.bus_address);
          end else if (r.action == ACT_PPU_READ) begin
            chr_bank         = r.bus_address[12] ? chr_bank_high : chr_bank_low;
            o.hit            = 1'b1;
            o.mapped_address = {1'b0, chr_bank, r.bus_address[11:0]};
          end
        end
      end
    endcase
    o.mirroring = mirror;
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      prg_count     = PRG_COUNT_RESET;
      chr_count     = 5'd0;
      load_value    = '0;
      load_count    = '0;
      control       = CONTROL_RESET;
      chr_sel_low   = '0;
      chr_sel_high  = '0;
      prg_sel       = '0;
      chr_bank_low  = 5'd0;
      chr_bank_high = 5'd1;
      prg_bank_low  = 4'd0;
      prg_bank_high = last_prg_bank();
      mirror        = 2'd0;
      expected_rsps.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding: %p", rsp);
          fail_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
            fail_count++;
          end
          if (rsp.mapped_address !== want.mapped_address) begin
            $error("mapped_address: expected %05h, got %05h",
                   want.mapped_address, rsp.mapped_address);
            fail_count++;
          end
          if (rsp.mirroring !== want.mirroring) begin
            $error("mirroring: expected %0d, got %0d", want.mirroring, rsp.mirroring);
            fail_count++;
          end
        end
      end
      if (req_valid && !req_stall) expected_rsps.push_back(map_access(req));
      if (cfg_write) begin
        case (cfg_index)
          CFG_PRG_BANK_COUNT: begin
            prg_count     = cfg_data;
            prg_bank_high = last_prg_bank();
          end
          default: chr_count = cfg_data;
        endcase
      end
    end
    fails       <= fail_count;
    outstanding <= expected_rsps.size();
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives bus accesses and bank count writes into the serial bank switch
// mapper and gives the verdict. A directed opening touches the address
// extremes, every access type, a reset write and serial loads. Random traffic
// follows under several bank count settings and three idle mixes on both
// ports. The run also includes a long response hold-off and a drain pause.
// Checking is done by sbsm_bus_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import sbsm_pkg::*;

  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 270;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SEND_IDLE[PHASES] = '{37, 37, 58, 58, 0, 0};
  localparam int RECV_IDLE[PHASES] = '{58, 58, 37, 37, 0, 0};
  localparam logic [4:0] PRG_SETTING[PHASES] = '{5'd16, 5'd1, 5'd8, 5'd0, 5'd31, 5'd2};
  localparam logic [4:0] CHR_SETTING[PHASES] = '{5'd0, 5'd16, 5'd4, 5'd1, 5'd31, 5'd0};

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req       = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_write = 1'b0;
  logic [0:0]           cfg_index = CFG_PRG_BANK_COUNT;
  logic [CFG_WIDTH-1:0] cfg_data  = '0;
  int                   fails;
  int                   outstanding;
  int                   send_idle_pct = 37;
  int                   recv_idle_pct = 58;
  int                   hold_requests = 0;

  always #5 clk = ~clk;

  serial_bank_switch_mapper i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sbsm_bus_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fails       (fails),
    .outstanding (outstanding)
  );

  initial begin
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic offer(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_bank_counts(input logic [4:0] prg, input logic [4:0] chr);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PRG_BANK_COUNT;
    cfg_data  <= prg;
    @(posedge clk);
    cfg_index <= CFG_CHR_BANK_COUNT;
    cfg_data  <= chr;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic req_t make_req(input logic [1:0] action, input logic [15:0] addr,
                                    input logic [7:0] data);
    req_t r;
    r.action      = action;
    r.bus_address = addr;
    r.write_data  = data;
    return r;
  endfunction

  task automatic load_register(input logic [1:0] target, input logic [4:0] value);
    for (int i = 0; i < 5; i++)
      offer(make_req(ACT_CPU_WRITE, {1'b1, target, 13'($urandom)},
                     {1'b0, 6'($urandom), value[i]}));
  endtask

  function automatic req_t random_access();
    req_t r;
    int   pick;
    int   sub;
    pick          = $urandom_range(99);
    sub           = $urandom_range(99);
    r.write_data  = 8'($urandom);
    r.bus_address = 16'($urandom);
    if (pick < 30) begin
      r.action = ACT_CPU_READ;
      if (sub < 85) r.bus_address[15] = 1'b1;
    end else if (pick < 65) begin
      r.action = ACT_CPU_WRITE;
      if (sub < 80) begin
        r.bus_address[15] = 1'b1;
        r.write_data[7]   = 1'b0;
      end else if (sub < 88) begin
        r.bus_address[15] = 1'b1;
        r.write_data[7]   = 1'b1;
      end else begin
        r.bus_address[15] = 1'b0;
      end
    end else begin
      r.action = (pick < 90) ? ACT_PPU_READ : ACT_PPU_WRITE;
      if (sub < 85) r.bus_address[15:13] = 3'b000;
    end
    return r;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer(make_req(ACT_CPU_READ, 16'h7FFF, 8'h00));
    offer(make_req(ACT_CPU_READ, 16'h8000, 8'hFF));
    offer(make_req(ACT_CPU_READ, 16'hBFFF, 8'h00));
    offer(make_req(ACT_CPU_READ, 16'hFFFF, 8'hFF));
    offer(make_req(ACT_PPU_READ, 16'h0000, 8'h00));
    offer(make_req(ACT_PPU_WRITE, 16'h1FFF, 8'hFF));
    offer(make_req(ACT_PPU_READ, 16'h2000, 8'h00));
    offer(make_req(ACT_PPU_WRITE, 16'hFFFF, 8'hFF));
    offer(make_req(ACT_CPU_WRITE, 16'h7FFF, 8'h01));
    offer(make_req(ACT_CPU_WRITE, 16'h8000, 8'h01));
    offer(make_req(ACT_CPU_WRITE, 16'hE000, 8'h01));
    offer(make_req(ACT_CPU_WRITE, 16'hFFFF, 8'hFF));
    load_register(TGT_CONTROL, 5'h0F);
    load_register(TGT_PRG, 5'h1F);
    offer(make_req(ACT_CPU_READ, 16'hC000, 8'h00));
    offer(make_req(ACT_CPU_READ, 16'h8000, 8'h00));

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = SEND_IDLE[p];
      recv_idle_pct <= RECV_IDLE[p];
      if (p > 0) begin
        drain();
        repeat (2) @(posedge clk);
        write_bank_counts(PRG_SETTING[p], CHR_SETTING[p]);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 120) hold_requests <= hold_requests + 1;
        if (p == 3 && n == 100) drain();
        offer(random_access());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/sbsm_pkg.sv
rtl/sbsm_regs.sv
rtl/sbsm_xlate.sv
rtl/serial_bank_switch_mapper.sv
sim/sbsm_bus_checker.sv
sim/tb_top.sv
